// ----- sv/cdfd_pkg.sv -----
// Shared types, codes and sizes for the charge-division frame decoder.
package cdfd_pkg;

    localparam int VALUE_W      = 12;
    localparam int HALF_W       = 6;
    localparam int SUM_W        = VALUE_W + 1;
    localparam int DEN_W        = SUM_W + 1;
    localparam int NUM_W        = 26;
    localparam int QUOT_W       = VALUE_W;
    localparam int STEP_W       = $clog2(QUOT_W);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [VALUE_W-1:0] FULL_SCALE = 12'hFFF;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_ERROR    = 1'b1;

    localparam logic [1:0] TAG_LOW    = 2'b00;
    localparam logic [1:0] TAG_HIGH_A = 2'b01;
    localparam logic [1:0] TAG_HIGH_B = 2'b10;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] position;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } out_t;

    // Work handed from the frame assembler to the divider side.
    typedef struct packed {
        logic               is_error;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } cmd_t;

endpackage

// ----- sv/cdfd_front.sv -----
// Frame assembler: tracks the byte phase, rebuilds A and B and issues commands.
module cdfd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cdfd_pkg::in_t  s_data,
    input  logic           q_full,
    output logic           q_push,
    output cdfd_pkg::cmd_t q_push_data
);
    import cdfd_pkg::*;

    typedef enum logic [3:0] {
        PH_LOW_A  = 4'b0001,
        PH_HIGH_A = 4'b0010,
        PH_LOW_B  = 4'b0100,
        PH_HIGH_B = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_first_reg, acc_first_next;
    logic [VALUE_W-1:0] acc_second_reg, acc_second_next;
    logic [1:0]         tag;
    logic [HALF_W-1:0]  val;
    logic [VALUE_W-1:0] second_full;
    logic               fire;
    logic               tag_bad;
    logic               extreme;

    assign s_ready     = !q_full;
    assign fire        = s_valid && s_ready;
    assign tag         = s_data.data_byte[7:6];
    assign val         = s_data.data_byte[5:0];
    assign second_full = {val, acc_second_reg[HALF_W-1:0]};
    assign extreme     = (acc_first_reg == '0) || (acc_first_reg == FULL_SCALE) ||
                         (second_full == '0) || (second_full == FULL_SCALE);

    always_comb begin
        phase_next      = phase_reg;
        acc_first_next  = acc_first_reg;
        acc_second_next = acc_second_reg;
        tag_bad         = 1'b0;
        q_push          = 1'b0;
        q_push_data     = '0;
        if (fire) begin
            if (s_data.op == OP_RESYNC) begin
                phase_next = PH_LOW_A;
            end else begin
                case (phase_reg)
                    PH_LOW_A: begin
                        if (tag == TAG_LOW) begin
                            acc_first_next = {{(VALUE_W-HALF_W){1'b0}}, val};
                            phase_next     = PH_HIGH_A;
                        end else begin
                            tag_bad = 1'b1;
                        end
                    end
                    PH_HIGH_A: begin
                        if (tag == TAG_HIGH_A) begin
                            acc_first_next = {val, acc_first_reg[HALF_W-1:0]};
                            phase_next     = PH_LOW_B;
                        end else begin
                            tag_bad = 1'b1;
                        end
                    end
                    PH_LOW_B: begin
                        if (tag == TAG_LOW) begin
                            acc_second_next = {{(VALUE_W-HALF_W){1'b0}}, val};
                            phase_next      = PH_HIGH_B;
                        end else begin
                            tag_bad = 1'b1;
                        end
                    end
                    PH_HIGH_B: begin
                        if (tag == TAG_HIGH_B) begin
                            acc_second_next = second_full;
                            phase_next      = PH_LOW_A;
                            if (!extreme) begin
                                q_push                   = 1'b1;
                                q_push_data.is_error     = 1'b0;
                                q_push_data.first_value  = acc_first_reg;
                                q_push_data.second_value = second_full;
                            end
                        end else begin
                            tag_bad = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_LOW_A;
                    end
                endcase
            end
        end
        // A misplaced tag leaves the phase and both signals untouched.
        if (tag_bad) begin
            q_push               = 1'b1;
            q_push_data.is_error = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LOW_A;
            acc_first_reg  <= '0;
            acc_second_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            acc_first_reg  <= acc_first_next;
            acc_second_reg <= acc_second_next;
        end
    end

endmodule

// ----- sv/cdfd_queue.sv -----
// Small command queue between the frame assembler and the divider.
module cdfd_queue #(
    parameter int DEPTH = cdfd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cdfd_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output cdfd_pkg::cmd_t pop_data,
    output logic           empty
);
    import cdfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/cdfd_back.sv -----
// Divider side: works out the rounded position and holds the result register.
module cdfd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  cdfd_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output cdfd_pkg::out_t m_data
);
    import cdfd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   dvs_reg, dvs_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] first_reg, first_next;
    logic [VALUE_W-1:0] second_reg, second_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;
    logic               out_free;
    logic [SUM_W-1:0]   sum;
    logic [NUM_W-1:0]   numer;
    logic [NUM_W-1:0]   diff;
    logic               fits;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // 8190*A + (A+B) over 2*(A+B) gives A/(A+B) scaled to full range, rounded half up.
    assign sum   = SUM_W'(q_head.first_value) + SUM_W'(q_head.second_value);
    assign numer = (NUM_W'(q_head.first_value) << 13) - (NUM_W'(q_head.first_value) << 1)
                 + NUM_W'(sum);
    assign diff  = rem_reg - dvs_reg;
    assign fits  = (rem_reg >= dvs_reg);

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    if (q_head.is_error) begin
                        if (out_free) begin
                            q_pop             = 1'b1;
                            m_valid_next      = 1'b1;
                            m_data_next       = '0;
                            m_data_next.kind  = KIND_ERROR;
                        end
                    end else begin
                        q_pop       = 1'b1;
                        rem_next    = numer;
                        dvs_next    = NUM_W'({sum, 1'b0}) << (QUOT_W - 1);
                        quot_next   = '0;
                        step_next   = STEP_W'(QUOT_W - 1);
                        first_next  = q_head.first_value;
                        second_next = q_head.second_value;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle, MSB first.
                if (fits) begin
                    rem_next = diff;
                end
                quot_next = {quot_reg[QUOT_W-2:0], fits};
                dvs_next  = dvs_reg >> 1;
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.kind         = KIND_POSITION;
                    m_data_next.position     = quot_reg;
                    m_data_next.first_value  = first_reg;
                    m_data_next.second_value = second_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/charge_division_frame_decoder_core.sv -----
// Top level of the charge-division frame decoder.
//
// The block takes one detector byte per item and rebuilds two 12-bit signals
// A and B from four-byte frames (low A, high A, low B, high B; the tag in
// bits 7:6 marks low, high-A and high-B bytes, and the phase tells low A from
// low B). A completed frame whose signals both lie strictly between 0 and
// 4095 yields one result item carrying round(4095*A/(A+B)), rounded half up,
// along with A and B; a frame with an extreme signal yields nothing. A byte
// whose tag does not fit the current phase yields one framing-error item and
// leaves the frame state as it was. A resync item returns the phase to the
// start of a frame and yields nothing. Bytes are accepted one per cycle as
// long as the command queue between the frame assembler and the divider has
// room. Each completed frame occupies the divider for a load step, 12
// restoring-division steps and a step that writes the result register, which
// waits while the output is stalled; the shared divider limits the sustained
// byte rate. An error item skips the division. The result register frees the
// front side from output stalls until the queue fills.
module charge_division_frame_decoder_core #(
    parameter int QUEUE_DEPTH = cdfd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cdfd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cdfd_pkg::out_t m_data
);
    import cdfd_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_push_data;
    cmd_t q_head;

    // Front side: phase tracking and frame assembly.
    cdfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // Decoupling queue, so the byte stream keeps flowing while a divide runs.
    cdfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    // Back side: iterative divider and result register.
    cdfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // The front side must never hand over a command the queue cannot hold.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // A framing error carries no position and no signals.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_ERROR) |->
        (m_data.position == '0 && m_data.first_value == '0 && m_data.second_value == '0))
        else $error("framing error item with nonzero payload");

    // Position results only come from frames whose signals are not extreme.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_POSITION) |->
        (m_data.first_value != '0 && m_data.first_value != FULL_SCALE &&
         m_data.second_value != '0 && m_data.second_value != FULL_SCALE))
        else $error("position result from an extreme frame");

    // A popped command must come from a queue that holds one.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

endmodule
